/* rtl/pfe_pkg.sv */
// Package for the palette fade engine: sizes, operation and register codes,
// the command passed from front to back, and the per-entry fade step.
// No dependencies.
`timescale 1ns / 1ps

package pfe_pkg;

    localparam int ENTRIES   = 64;
    localparam int LAST_STEP = 21;

    localparam int IDX_W   = 6;
    localparam int LEVEL_W = 3;
    localparam int CFG_W   = 6;
    localparam int ENT_W   = $clog2(ENTRIES);
    localparam int SLOTS   = 2 * ENTRIES;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int POS_W   = ((ENT_W > IDX_W) ? ENT_W : IDX_W) + 1;
    localparam int STEP_W  = (LAST_STEP > 1) ? $clog2(LAST_STEP + 1) : 1;
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 2) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [1:0] REG_FADE_MODE     = 2'd0;
    localparam logic [1:0] REG_FIRST_ENTRY   = 2'd1;
    localparam logic [1:0] REG_EXTRA_ENTRIES = 2'd2;
    localparam logic [1:0] REG_SKIP_SECOND   = 2'd3;

    localparam logic [2:0] MODE_NONE      = 3'd0;
    localparam logic [2:0] MODE_FADE_IN   = 3'd1;
    localparam logic [2:0] MODE_FADE_OUT  = 3'd2;
    localparam logic [2:0] MODE_FLASH_IN  = 3'd3;
    localparam logic [2:0] MODE_FLASH_OUT = 3'd4;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;
    localparam logic [LEVEL_W-1:0] LEVEL_ONE = LEVEL_W'(1);

    typedef struct packed {
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
    } color_t;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic               to_target;
        logic [SLOT_W-1:0]  slot;
        color_t             color;
    } cmd_t;

    function automatic color_t step_color(input color_t cur, input color_t tgt,
                                          input logic [2:0] mode);
        color_t res;
        begin
            res = cur;
            case (mode)
                MODE_FADE_IN:
                begin
                    if (tgt.blue > cur.blue) res.blue = cur.blue + LEVEL_ONE;
                    else if (tgt.green > cur.green) res.green = cur.green + LEVEL_ONE;
                    else if (tgt.red > cur.red) res.red = cur.red + LEVEL_ONE;
                end
                MODE_FADE_OUT:
                begin
                    if (cur.red != '0) res.red = cur.red - LEVEL_ONE;
                    else if (cur.green != '0) res.green = cur.green - LEVEL_ONE;
                    else if (cur.blue != '0) res.blue = cur.blue - LEVEL_ONE;
                end
                MODE_FLASH_IN:
                begin
                    if (tgt.blue < cur.blue) res.blue = cur.blue - LEVEL_ONE;
                    else if (tgt.green < cur.green) res.green = cur.green - LEVEL_ONE;
                    else if (tgt.red < cur.red) res.red = cur.red - LEVEL_ONE;
                end
                MODE_FLASH_OUT:
                begin
                    if (cur.red != LEVEL_MAX) res.red = cur.red + LEVEL_ONE;
                    else if (cur.green != LEVEL_MAX) res.green = cur.green + LEVEL_ONE;
                    else if (cur.blue != LEVEL_MAX) res.blue = cur.blue + LEVEL_ONE;
                end
                default:
                begin
                    res = cur;
                end
            endcase
            return res;
        end
    endfunction

endpackage

/* rtl/pfe_front.sv */
// Front end of the palette fade engine: accepts input transactions and
// classifies them into commands for the back end. Depends on pfe_pkg.
`timescale 1ns / 1ps

module pfe_front (
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  operation,
    input  logic [1:0]                  bank_select,
    input  logic [pfe_pkg::IDX_W-1:0]   entry_index,
    input  logic [pfe_pkg::LEVEL_W-1:0] red_level,
    input  logic [pfe_pkg::LEVEL_W-1:0] green_level,
    input  logic [pfe_pkg::LEVEL_W-1:0] blue_level,
    input  logic                        q_full,
    output logic                        push,
    output pfe_pkg::cmd_t               push_cmd
);
    import pfe_pkg::*;

    logic              in_range;
    logic [SLOT_W-1:0] slot;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;
    assign in_range = POS_W'(entry_index) < POS_W'(ENTRIES);
    assign slot     = bank_select[1] ? SLOT_W'(ENTRIES) + SLOT_W'(entry_index)
                                     : SLOT_W'(entry_index);

    always_comb
    begin
        push_cmd.to_target   = bank_select[0];
        push_cmd.slot        = slot;
        push_cmd.color.red   = red_level;
        push_cmd.color.green = green_level;
        push_cmd.color.blue  = blue_level;
        unique case (operation)
            OP_WRITE: push_cmd.kind = in_range ? CMD_WRITE : CMD_NOP;
            OP_READ:  push_cmd.kind = in_range ? CMD_READ : CMD_NOP;
            OP_TICK:  push_cmd.kind = CMD_TICK;
            default:  push_cmd.kind = CMD_NOP;
        endcase
    end

endmodule

/* rtl/pfe_queue.sv */
// Command queue between front and back of the palette fade engine.
// Depends on pfe_pkg.
`timescale 1ns / 1ps

module pfe_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  pfe_pkg::cmd_t push_cmd,
    output logic          q_full,
    input  logic          pop,
    output logic          q_valid,
    output pfe_pkg::cmd_t q_cmd
);
    import pfe_pkg::*;

    cmd_t               slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;

    assign q_full  = count_reg == Q_CNT_W'(Q_DEPTH);
    assign q_valid = count_reg != '0;
    assign q_cmd   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0
                                                                : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0
                                                                : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) count_next = count_reg + 1'b1;
        else if (pop && !push) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) slot_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

/* rtl/pfe_back.sv */
// Back end of the palette fade engine: configuration registers, palette
// memories, fade walk sequencer and result register. Depends on pfe_pkg.
`timescale 1ns / 1ps

module pfe_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [1:0]                  cfg_index,
    input  logic [pfe_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        q_valid,
    input  pfe_pkg::cmd_t               q_cmd,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [pfe_pkg::LEVEL_W-1:0] read_red,
    output logic [pfe_pkg::LEVEL_W-1:0] read_green,
    output logic [pfe_pkg::LEVEL_W-1:0] read_blue,
    output logic                        fade_finished
);
    import pfe_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_RDWAIT = 4'b0010,
        S_WALK   = 4'b0100,
        S_DRAIN  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [2:0]       mode_reg;
    logic [IDX_W-1:0] first_reg;
    logic [IDX_W-1:0] extra_reg;
    logic             skip_reg;
    logic [STEP_W-1:0] step_reg, step_next;

    logic [POS_W-1:0]  walk_pos_reg, walk_pos_next;
    logic [POS_W-1:0]  walk_end_reg, walk_end_next;
    logic              walk_bank_reg, walk_bank_next;
    logic              walk_do_b_reg, walk_do_b_next;
    logic              pend_reg, pend_next;
    logic [SLOT_W-1:0] pend_slot_reg, pend_slot_next;

    color_t            work_mem [SLOTS];
    color_t            targ_mem [SLOTS];
    logic [SLOTS-1:0]  work_vld_reg;
    logic [SLOTS-1:0]  targ_vld_reg;
    color_t            rd_work_reg, rd_targ_reg;
    logic              rd_work_vld_reg, rd_targ_vld_reg;
    logic              rd_sel_targ_reg;

    logic              rd_en;
    logic [SLOT_W-1:0] rd_slot;
    logic              rd_sel_targ_next;
    logic              wr_en;
    logic              wr_target;
    logic [SLOT_W-1:0] wr_slot;
    color_t            wr_color;

    logic              out_valid_reg, out_valid_next;
    color_t            out_color_reg, out_color_next;
    logic              out_fin_reg, out_fin_next;
    logic              load_out;

    logic              out_free;
    logic              tick_active;
    logic              skip_b;
    logic [POS_W-1:0]  range_last;
    logic [POS_W-1:0]  range_end;
    logic              range_empty;
    logic [SLOT_W-1:0] walk_slot;
    color_t            rd_cur, rd_tgt, stepped;
    logic              step_wrap;

    assign out_free    = !out_valid_reg || !out_stall;
    assign tick_active = (mode_reg >= MODE_FADE_IN) && (mode_reg <= MODE_FLASH_OUT);
    assign skip_b      = skip_reg && (mode_reg == MODE_FADE_IN || mode_reg == MODE_FLASH_IN);
    assign range_last  = POS_W'(first_reg) + POS_W'(extra_reg);
    assign range_end   = (range_last > POS_W'(ENTRIES - 1)) ? POS_W'(ENTRIES - 1) : range_last;
    assign range_empty = POS_W'(first_reg) >= POS_W'(ENTRIES);
    assign walk_slot   = walk_bank_reg ? SLOT_W'(ENTRIES) + SLOT_W'(walk_pos_reg)
                                       : SLOT_W'(walk_pos_reg);
    assign rd_cur      = rd_work_vld_reg ? rd_work_reg : '0;
    assign rd_tgt      = rd_targ_vld_reg ? rd_targ_reg : '0;
    assign stepped     = step_color(rd_cur, rd_tgt, mode_reg);
    assign step_wrap   = step_reg == STEP_W'(LAST_STEP);

    assign pop           = (state_reg == S_IDLE) && q_valid && out_free;
    assign out_valid     = out_valid_reg;
    assign read_red      = out_color_reg.red;
    assign read_green    = out_color_reg.green;
    assign read_blue     = out_color_reg.blue;
    assign fade_finished = out_fin_reg;

    always_comb
    begin
        state_next       = state_reg;
        step_next        = step_reg;
        walk_pos_next    = walk_pos_reg;
        walk_end_next    = walk_end_reg;
        walk_bank_next   = walk_bank_reg;
        walk_do_b_next   = walk_do_b_reg;
        pend_next        = 1'b0;
        pend_slot_next   = pend_slot_reg;
        rd_en            = 1'b0;
        rd_slot          = q_cmd.slot;
        rd_sel_targ_next = rd_sel_targ_reg;
        wr_en            = 1'b0;
        wr_target        = 1'b0;
        wr_slot          = q_cmd.slot;
        wr_color         = q_cmd.color;
        load_out         = 1'b0;
        out_color_next   = '0;
        out_fin_next     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    unique case (q_cmd.kind)
                        CMD_WRITE:
                        begin
                            wr_en     = 1'b1;
                            wr_target = q_cmd.to_target;
                            load_out  = 1'b1;
                        end
                        CMD_READ:
                        begin
                            rd_en            = 1'b1;
                            rd_sel_targ_next = q_cmd.to_target;
                            state_next       = S_RDWAIT;
                        end
                        CMD_TICK:
                        begin
                            if (!tick_active)
                            begin
                                load_out     = 1'b1;
                                out_fin_next = 1'b1;
                            end
                            else if (range_empty)
                            begin
                                state_next = S_DRAIN;
                            end
                            else
                            begin
                                walk_pos_next  = POS_W'(first_reg);
                                walk_end_next  = range_end;
                                walk_bank_next = 1'b0;
                                walk_do_b_next = !skip_b;
                                state_next     = S_WALK;
                            end
                        end
                        default:
                        begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            S_RDWAIT:
            begin
                load_out       = 1'b1;
                out_color_next = rd_sel_targ_reg ? rd_tgt : rd_cur;
                state_next     = S_IDLE;
            end
            S_WALK:
            begin
                rd_en          = 1'b1;
                rd_slot        = walk_slot;
                pend_next      = 1'b1;
                pend_slot_next = walk_slot;
                if (walk_pos_reg == walk_end_reg)
                begin
                    if (!walk_bank_reg && walk_do_b_reg)
                    begin
                        walk_bank_next = 1'b1;
                        walk_pos_next  = POS_W'(first_reg);
                    end
                    else
                    begin
                        state_next = S_DRAIN;
                    end
                end
                else
                begin
                    walk_pos_next = walk_pos_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                load_out     = 1'b1;
                out_fin_next = step_wrap;
                step_next    = step_wrap ? '0 : step_reg + 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (pend_reg)
        begin
            wr_en     = 1'b1;
            wr_target = 1'b0;
            wr_slot   = pend_slot_reg;
            wr_color  = stepped;
        end

        out_valid_next = load_out || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_NONE;
            first_reg <= '0;
            extra_reg <= '1;
            skip_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FADE_MODE:     mode_reg  <= cfg_data[2:0];
                REG_FIRST_ENTRY:   first_reg <= cfg_data[IDX_W-1:0];
                REG_EXTRA_ENTRIES: extra_reg <= cfg_data[IDX_W-1:0];
                REG_SKIP_SECOND:   skip_reg  <= cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            work_vld_reg  <= '0;
            targ_vld_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write && cfg_index == REG_FADE_MODE) step_reg <= '0;
            else step_reg <= step_next;
            if (wr_en && !wr_target) work_vld_reg[wr_slot] <= 1'b1;
            if (wr_en && wr_target) targ_vld_reg[wr_slot] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        walk_pos_reg    <= walk_pos_next;
        walk_end_reg    <= walk_end_next;
        walk_bank_reg   <= walk_bank_next;
        walk_do_b_reg   <= walk_do_b_next;
        pend_slot_reg   <= pend_slot_next;
        rd_sel_targ_reg <= rd_sel_targ_next;
        if (load_out)
        begin
            out_color_reg <= out_color_next;
            out_fin_reg   <= out_fin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && !wr_target) work_mem[wr_slot] <= wr_color;
        if (rd_en)
        begin
            rd_work_reg     <= work_mem[rd_slot];
            rd_work_vld_reg <= work_vld_reg[rd_slot];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && wr_target) targ_mem[wr_slot] <= wr_color;
        if (rd_en)
        begin
            rd_targ_reg     <= targ_mem[rd_slot];
            rd_targ_vld_reg <= targ_vld_reg[rd_slot];
        end
    end

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> out_free)
        else $error("result register loaded while occupied");

    a_writeback_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> $past(state_reg == S_WALK))
        else $error("write-back without a walk read");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WALK |-> walk_pos_reg < POS_W'(ENTRIES))
        else $error("walk position beyond last entry");

    a_finish_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN && step_wrap) |=> step_reg == '0)
        else $error("step count not restarted after completion");

endmodule

/* rtl/palette_fade_engine.sv */
// Palette fade engine top level. A write, a read of a missing entry and an idle
// tick load the result register when popped; a read first passes the memory read
// registers; an active tick walks the range in bank A, then bank B unless skipped,
// then drains. Throughput: one write per cycle while the output is not stalled;
// a read or an active tick holds the back end while a two-deep queue takes input.
// Reset is asynchronous; palette entries read as zero through per-entry valid flags.
`timescale 1ns / 1ps

module palette_fade_engine (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [1:0]                  cfg_index,
    input  logic [pfe_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  operation,
    input  logic [1:0]                  bank_select,
    input  logic [pfe_pkg::IDX_W-1:0]   entry_index,
    input  logic [pfe_pkg::LEVEL_W-1:0] red_level,
    input  logic [pfe_pkg::LEVEL_W-1:0] green_level,
    input  logic [pfe_pkg::LEVEL_W-1:0] blue_level,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [pfe_pkg::LEVEL_W-1:0] read_red,
    output logic [pfe_pkg::LEVEL_W-1:0] read_green,
    output logic [pfe_pkg::LEVEL_W-1:0] read_blue,
    output logic                        fade_finished
);
    import pfe_pkg::*;

    logic q_full;
    logic push;
    cmd_t push_cmd;
    logic pop;
    logic q_valid;
    cmd_t q_cmd;

    pfe_front u_front (
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .bank_select (bank_select),
        .entry_index (entry_index),
        .red_level   (red_level),
        .green_level (green_level),
        .blue_level  (blue_level),
        .q_full      (q_full),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    pfe_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .q_full   (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    pfe_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .q_valid       (q_valid),
        .q_cmd         (q_cmd),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .read_red      (read_red),
        .read_green    (read_green),
        .read_blue     (read_blue),
        .fade_finished (fade_finished)
    );

endmodule

/* bench/pfe_tb_pkg.sv */
// Scoreboard for the palette fade engine bench: mirrors the four palette banks,
// the fade registers and the step counter, and checks readouts in order.
// Depends on pfe_pkg for sizes, codes and the color type.
`timescale 1ns / 1ps

package pfe_tb_pkg;

    import pfe_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] BANK_WORK_A   = 2'd0;
    localparam logic [1:0] BANK_TARGET_A = 2'd1;
    localparam logic [1:0] BANK_WORK_B   = 2'd2;
    localparam logic [1:0] BANK_TARGET_B = 2'd3;

    localparam logic [2:0] MODE_SPARE_LO  = 3'd5;
    localparam logic [2:0] MODE_SPARE_MID = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI  = 3'd7;

    typedef struct packed {
        color_t levels;
        logic   finished;
    } readout_t;

    class palette_scoreboard;
        color_t      working[SLOTS];
        color_t      target[SLOTS];
        logic [2:0]  cur_mode;
        logic [5:0]  range_first;
        logic [5:0]  range_extra;
        logic        skip_bank_b;
        int unsigned tick_count;
        readout_t    pending[$];
        int          mismatches;
        int          readouts_checked;
        int          ticks_applied;
        int          fades_finished;

        function new();
            for (int i = 0; i < SLOTS; i++)
            begin
                working[i] = '0;
                target[i]  = '0;
            end
            cur_mode         = MODE_NONE;
            range_first      = 6'd0;
            range_extra      = 6'd63;
            skip_bank_b      = 1'b0;
            tick_count       = 0;
            mismatches       = 0;
            readouts_checked = 0;
            ticks_applied    = 0;
            fades_finished   = 0;
        endfunction

        function void write_register(logic [1:0] index, logic [CFG_W-1:0] data);
            case (index)
                REG_FADE_MODE:
                begin
                    cur_mode   = data[2:0];
                    tick_count = 0;
                end
                REG_FIRST_ENTRY:   range_first = data[5:0];
                REG_EXTRA_ENTRIES: range_extra = data[5:0];
                REG_SKIP_SECOND:   skip_bank_b = data[0];
                default:           ;
            endcase
        endfunction

        // channel order red, green, blue; in-modes scan from blue
        function color_t fade_entry(color_t cur, color_t tgt);
            logic [2:0] c[3];
            logic [2:0] t[3];
            c = '{cur.red, cur.green, cur.blue};
            t = '{tgt.red, tgt.green, tgt.blue};
            case (cur_mode)
                MODE_FADE_IN:
                    for (int k = 2; k >= 0; k--)
                        if (t[k] > c[k])
                        begin
                            c[k] = c[k] + 3'd1;
                            break;
                        end
                MODE_FLASH_IN:
                    for (int k = 2; k >= 0; k--)
                        if (t[k] < c[k])
                        begin
                            c[k] = c[k] - 3'd1;
                            break;
                        end
                MODE_FADE_OUT:
                    for (int k = 0; k < 3; k++)
                        if (c[k] != 3'd0)
                        begin
                            c[k] = c[k] - 3'd1;
                            break;
                        end
                MODE_FLASH_OUT:
                    for (int k = 0; k < 3; k++)
                        if (c[k] != 3'd7)
                        begin
                            c[k] = c[k] + 3'd1;
                            break;
                        end
                default: ;
            endcase
            return {c[0], c[1], c[2]};
        endfunction

        function void fade_bank(int base);
            for (int i = 0; i <= range_extra; i++)
            begin
                if (range_first + i >= ENTRIES)
                    break;
                working[base + range_first + i] =
                    fade_entry(working[base + range_first + i], target[base + range_first + i]);
            end
        endfunction

        function void accept_item(logic [1:0] op, logic [1:0] bank,
                                  logic [IDX_W-1:0] idx, color_t levels);
            readout_t want;
            int       slot;
            want = '0;
            slot = bank[1] * ENTRIES + idx;
            case (op)
                OP_WRITE:
                    if (idx < ENTRIES)
                    begin
                        if (bank[0])
                            target[slot] = levels;
                        else
                            working[slot] = levels;
                    end
                OP_READ:
                    if (idx < ENTRIES)
                        want.levels = bank[0] ? target[slot] : working[slot];
                OP_TICK:
                begin
                    ticks_applied++;
                    if (cur_mode < MODE_FADE_IN || cur_mode > MODE_FLASH_OUT)
                        want.finished = 1'b1;
                    else
                    begin
                        fade_bank(0);
                        if (!((cur_mode == MODE_FADE_IN || cur_mode == MODE_FLASH_IN)
                              && skip_bank_b))
                            fade_bank(ENTRIES);
                        tick_count++;
                        if (tick_count > LAST_STEP)
                        begin
                            tick_count    = 0;
                            want.finished = 1'b1;
                        end
                    end
                    if (want.finished)
                        fades_finished++;
                end
                default: ;
            endcase
            pending.push_back(want);
        endfunction

        function void check_readout(color_t levels, logic finished);
            readout_t want;
            readouts_checked++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("readout %0d arrived with nothing outstanding: r%0d g%0d b%0d f%0d",
                             readouts_checked, levels.red, levels.green, levels.blue, finished);
                return;
            end
            want = pending.pop_front();
            if (want.levels.red !== levels.red || want.levels.green !== levels.green ||
                want.levels.blue !== levels.blue || want.finished !== finished)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("readout %0d mismatch: expected r%0d g%0d b%0d f%0d, got r%0d g%0d b%0d f%0d",
                             readouts_checked, want.levels.red, want.levels.green,
                             want.levels.blue, want.finished, levels.red, levels.green,
                             levels.blue, finished);
            end
        endfunction
    endclass

endpackage

/* bench/tb_top.sv */
// Top-level bench for palette_fade_engine: directed and randomized transactions
// with random idling, configuration phases and back-pressure.
// Depends on pfe_pkg and pfe_tb_pkg.
`timescale 1ns / 1ps

module tb_top;

    import pfe_pkg::*;
    import pfe_tb_pkg::*;

    logic                 clk;
    logic                 rst_n       = 1'b0;
    logic                 cfg_write   = 1'b0;
    logic [1:0]           cfg_index   = '0;
    logic [CFG_W-1:0]     cfg_data    = '0;
    logic                 in_valid    = 1'b0;
    logic                 in_stall;
    logic [1:0]           operation   = '0;
    logic [1:0]           bank_select = '0;
    logic [IDX_W-1:0]     entry_index = '0;
    logic [LEVEL_W-1:0]   red_level   = '0;
    logic [LEVEL_W-1:0]   green_level = '0;
    logic [LEVEL_W-1:0]   blue_level  = '0;
    logic                 out_valid;
    logic                 out_stall   = 1'b0;
    logic [LEVEL_W-1:0]   read_red;
    logic [LEVEL_W-1:0]   read_green;
    logic [LEVEL_W-1:0]   read_blue;
    logic                 fade_finished;

    int                   send_idle_pct   = 0;
    int                   recv_stall_pct  = 0;
    int                   hold_cycles_req = 0;
    int                   items_sent      = 0;
    palette_scoreboard    sb;

    palette_fade_engine dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #15_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles_req != 0)
            begin
                hold_left       = hold_cycles_req;
                hold_cycles_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_readout({read_red, read_green, read_blue}, fade_finished);
    end

    task automatic send_item(logic [1:0] op, logic [1:0] bank, logic [IDX_W-1:0] idx,
                             color_t levels);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid    <= 1'b0;
            operation   <= 2'($urandom);
            entry_index <= IDX_W'($urandom);
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        bank_select <= bank;
        entry_index <= idx;
        red_level   <= levels.red;
        green_level <= levels.green;
        blue_level  <= levels.blue;
        do
            @(posedge clk);
        while (in_stall);
        sb.accept_item(op, bank, idx, levels);
        items_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_register(logic [1:0] index, logic [CFG_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_register(index, data);
    endtask

    task automatic configure(logic [2:0] mode, logic [5:0] first, logic [5:0] extra,
                             logic skip);
        drain();
        set_register(REG_FADE_MODE, CFG_W'(mode));
        set_register(REG_FIRST_ENTRY, first);
        set_register(REG_EXTRA_ENTRIES, extra);
        set_register(REG_SKIP_SECOND, CFG_W'(skip));
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // bias addresses into the fade range so steps act on written entries
    task automatic random_item(logic [5:0] first, logic [5:0] extra);
        int               pick;
        logic [1:0]       op;
        logic [IDX_W-1:0] idx;
        pick = $urandom_range(99);
        if (pick < 35)
            op = OP_TICK;
        else if (pick < 70)
            op = OP_WRITE;
        else if (pick < 96)
            op = OP_READ;
        else
            op = OP_UNUSED;
        if ($urandom_range(99) < 75)
            idx = IDX_W'(first + $urandom_range(extra));
        else
            idx = IDX_W'($urandom);
        send_item(op, 2'($urandom), idx, color_t'($urandom));
    endtask

    initial
    begin
        logic [2:0] mode;
        logic [5:0] first;
        logic [5:0] extra;
        logic       skip;
        int         failures;

        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(OP_READ,   BANK_WORK_A,   6'd0,  9'o000);
        send_item(OP_READ,   BANK_TARGET_B, 6'd63, 9'o000);
        send_item(OP_WRITE,  BANK_WORK_A,   6'd0,  9'o777);
        send_item(OP_WRITE,  BANK_TARGET_A, 6'd0,  9'o000);
        send_item(OP_WRITE,  BANK_WORK_B,   6'd63, 9'o000);
        send_item(OP_WRITE,  BANK_TARGET_B, 6'd63, 9'o777);
        send_item(OP_WRITE,  BANK_WORK_A,   6'd1,  9'o052);
        send_item(OP_WRITE,  BANK_TARGET_A, 6'd1,  9'o357);
        send_item(OP_UNUSED, BANK_TARGET_B, 6'd63, 9'o777);
        send_item(OP_TICK,   BANK_WORK_A,   6'd0,  9'o000);
        send_item(OP_READ,   BANK_WORK_A,   6'd0,  9'o000);
        configure(MODE_FADE_IN, 6'd0, 6'd63, 1'b0);
        send_item(OP_TICK,   BANK_WORK_A,   6'd0,  9'o000);
        send_item(OP_READ,   BANK_WORK_B,   6'd63, 9'o000);
        send_item(OP_READ,   BANK_WORK_A,   6'd1,  9'o000);
        configure(MODE_FADE_OUT, 6'd63, 6'd63, 1'b0);
        send_item(OP_TICK,   BANK_WORK_A,   6'd0,  9'o000);
        send_item(OP_READ,   BANK_WORK_A,   6'd63, 9'o000);
        send_item(OP_READ,   BANK_WORK_B,   6'd63, 9'o000);
        configure(MODE_FLASH_IN, 6'd0, 6'd1, 1'b1);
        send_item(OP_TICK,   BANK_WORK_A,   6'd0,  9'o000);
        send_item(OP_READ,   BANK_WORK_A,   6'd0,  9'o000);
        send_item(OP_READ,   BANK_WORK_B,   6'd0,  9'o000);
        configure(MODE_FLASH_OUT, 6'd0, 6'd0, 1'b0);
        send_item(OP_TICK,   BANK_WORK_A,   6'd0,  9'o000);
        send_item(OP_READ,   BANK_WORK_A,   6'd0,  9'o000);
        configure(MODE_SPARE_MID, 6'd5, 6'd9, 1'b1);
        send_item(OP_TICK,   BANK_WORK_A,   6'd0,  9'o000);

        for (int p = 0; p < 12; p++)
        begin
            case (p)
                0: {mode, first, extra, skip} = {MODE_FADE_IN,   6'd0,  6'd63, 1'b0};
                1: {mode, first, extra, skip} = {MODE_FADE_OUT,  6'd63, 6'd63, 1'b0};
                2: {mode, first, extra, skip} = {MODE_FLASH_IN,  6'd0,  6'd0,  1'b1};
                3: {mode, first, extra, skip} = {MODE_FLASH_OUT, 6'd40, 6'd30, 1'b0};
                4: {mode, first, extra, skip} = {MODE_NONE,      6'd10, 6'd5,  1'b1};
                5: {mode, first, extra, skip} = {MODE_FADE_IN,   6'd20, 6'd12, 1'b1};
                6: {mode, first, extra, skip} = {MODE_SPARE_HI,  6'd0,  6'd63, 1'b0};
                7: {mode, first, extra, skip} = {MODE_FLASH_IN,  6'd50, 6'd20, 1'b0};
                8: {mode, first, extra, skip} = {MODE_SPARE_LO,  6'd3,  6'd3,  1'b0};
                default:
                begin
                    mode  = 3'($urandom_range(7));
                    first = 6'($urandom);
                    extra = 6'($urandom_range(15));
                    skip  = 1'($urandom);
                end
            endcase
            configure(mode, first, extra, skip);
            case (p % 4)
                0:       {send_idle_pct, recv_stall_pct} = {32'd0,  32'd0};
                1:       {send_idle_pct, recv_stall_pct} = {32'd79, 32'd0};
                2:       {send_idle_pct, recv_stall_pct} = {32'd0,  32'd79};
                default: {send_idle_pct, recv_stall_pct} = {32'd27, 32'd27};
            endcase
            for (int n = 0; n < 155; n++)
            begin
                if (p == 0 && n == 30)
                    hold_cycles_req = 400;
                if (p == 5 && n == 80)
                    drain();
                random_item(first, extra);
            end
            send_idle_pct  = 0;
            recv_stall_pct = 0;
        end

        drain();
        repeat (10) @(posedge clk);
        failures = sb.mismatches + sb.pending.size();
        if (sb.pending.size() != 0)
            $display("%0d readouts never arrived", sb.pending.size());
        $display("Sent %0d transactions over 12 register settings; %0d readouts checked",
                 items_sent, sb.readouts_checked);
        $display("Fade steps %0d, completions flagged %0d, mismatches %0d",
                 sb.ticks_applied, sb.fades_finished, sb.mismatches);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
